### src/soc_io_register_block_assert.svh
// Assertion macros for the soc_io_register_block RTL.
// Included by the top level; needs no package.
`ifndef SOC_IO_REGISTER_BLOCK_ASSERT_SVH
`define SOC_IO_REGISTER_BLOCK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIRB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sirb_pkg.sv
// Shared types and constants for the I/O register block.
// Used by sirb_ctrl, sirb_datapath and the top level.
`default_nettype none

package sirb_pkg;

    localparam int EEPROM_DEPTH_DEF = 1024;
    localparam int REG_WINDOW_DEF   = 96;

    localparam int OFF_W      = 7;
    localparam int DATA_W     = 16;
    localparam int OP_W       = 2;
    localparam int S_TDATA_W  = 24;
    localparam int GPIO_PORTS = 3;

    // transaction kinds carried on tuser
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK1 = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK2 = 2'd3;

    // register offsets with their own behavior
    localparam logic [OFF_W-1:0] OFF_GPIO_FIRST  = 7'h01;
    localparam logic [OFF_W-1:0] OFF_GPIO_LAST   = 7'h0f;
    localparam logic [OFF_W-1:0] OFF_IRQ_STATUS  = 7'h22;
    localparam logic [OFF_W-1:0] OFF_ADC_CTRL    = 7'h25;
    localparam logic [OFF_W-1:0] OFF_UART_STATUS = 7'h31;
    localparam logic [OFF_W-1:0] OFF_UART_TX     = 7'h35;
    localparam logic [OFF_W-1:0] OFF_I2C_CMD     = 7'h58;
    localparam logic [OFF_W-1:0] OFF_I2C_STATUS  = 7'h59;
    localparam logic [OFF_W-1:0] OFF_I2C_DEV     = 7'h5b;
    localparam logic [OFF_W-1:0] OFF_I2C_SUB     = 7'h5c;
    localparam logic [OFF_W-1:0] OFF_I2C_DOUT    = 7'h5d;
    localparam logic [OFF_W-1:0] OFF_I2C_DIN     = 7'h5e;

    localparam logic [DATA_W-1:0] ADC_W1C_MASK   = 16'h2000;
    localparam logic [DATA_W-1:0] UART_STAT_READ = 16'h0003;
    localparam logic [DATA_W-1:0] I2C_DEV_MASK   = 16'h0006;
    localparam logic [DATA_W-1:0] I2C_CMD_READ   = 16'h0040;
    localparam logic [DATA_W-1:0] IRQ_TICK1      = 16'h0001;
    localparam logic [DATA_W-1:0] IRQ_TICK2      = 16'h0002;
    localparam logic [DATA_W-1:0] I2C_DONE       = 16'h0001;

    typedef struct packed {
        logic clear_step;  // zero one EEPROM byte, advance sweep
        logic capture;     // latch the incoming transaction
        logic execute;     // apply register updates, issue memory accesses
        logic finish;      // form the result into the output register
    } cmd_t;

    typedef struct packed {
        logic clear_last;  // sweep is at the final EEPROM byte
        logic out_free;    // output register can take a result this cycle
    } status_t;

endpackage

`default_nettype wire

### src/sirb_ctrl.sv
// Controller state machine for the I/O register block.
// Depends on sirb_pkg for the command and status structs.
`default_nettype none

module sirb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output sirb_pkg::cmd_t    cmd,
    input  sirb_pkg::status_t status
);
    import sirb_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register frees up
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/sirb_datapath.sv
// Datapath of the I/O register block: special registers, register file
// memory, EEPROM memory and output register. Depends on sirb_pkg.
`default_nettype none

module sirb_datapath #(
    parameter int EEPROM_DEPTH = sirb_pkg::EEPROM_DEPTH_DEF,
    parameter int REG_WINDOW   = sirb_pkg::REG_WINDOW_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [sirb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [sirb_pkg::OP_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sirb_pkg::DATA_W-1:0]    m_tdata,
    input  sirb_pkg::cmd_t                 cmd,
    output sirb_pkg::status_t              status
);
    import sirb_pkg::*;

    localparam int EEP_AW = $clog2(EEPROM_DEPTH);
    localparam int RF_AW  = $clog2(REG_WINDOW);
    localparam logic [11:0] EEP_D1 = 12'(EEPROM_DEPTH);
    localparam logic [11:0] EEP_D2 = 12'(2 * EEPROM_DEPTH);

    // latched transaction
    logic [OP_W-1:0]   op_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [DATA_W-1:0] wd_reg;

    // registers with side effects, kept in flops
    logic [DATA_W-1:0] gpio_buf_reg  [GPIO_PORTS];
    logic [DATA_W-1:0] gpio_dir_reg  [GPIO_PORTS];
    logic [DATA_W-1:0] gpio_attr_reg [GPIO_PORTS];
    logic [DATA_W-1:0] gpio_spec_reg [GPIO_PORTS];
    logic [DATA_W-1:0] irq_reg;
    logic [DATA_W-1:0] adc_reg;
    logic [DATA_W-1:0] i2c_cmd_reg;
    logic [DATA_W-1:0] i2c_stat_reg;
    logic [DATA_W-1:0] i2c_dev_reg;
    logic [DATA_W-1:0] i2c_sub_reg;
    logic [DATA_W-1:0] i2c_dout_reg;
    logic [DATA_W-1:0] i2c_din_reg;

    // plain registers live in memory; an entry not yet written reads zero
    logic [DATA_W-1:0]     rf_mem [REG_WINDOW];
    logic [REG_WINDOW-1:0] rf_valid_reg;
    logic [DATA_W-1:0]     rf_q_reg;
    logic                  rf_hit_reg;

    logic [7:0]        eep_mem [EEPROM_DEPTH];
    logic [7:0]        eep_q_reg;
    logic              eep_rd_reg;
    logic [EEP_AW-1:0] clr_cnt_reg;

    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;

    logic              in_win;
    logic              is_flop;
    logic              is_write;
    logic              rf_wr;
    logic              i2c_go;
    logic              eep_wr;
    logic [RF_AW-1:0]  rf_idx;
    logic [11:0]       eep_raw;
    logic [11:0]       eep_m1;
    logic [11:0]       eep_m2;
    logic [EEP_AW-1:0] eep_addr;
    logic [DATA_W-1:0] flop_rd;
    logic [DATA_W-1:0] result;

    function automatic logic [DATA_W-1:0] gpio_data(
        input logic [DATA_W-1:0] b,
        input logic [DATA_W-1:0] d,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] s
    );
        logic [DATA_W-1:0] pull;
        logic [DATA_W-1:0] v;
        pull = ~d & ~a;
        v    = b & (d | pull);
        v    = v ^ (d & ~a);
        return v & ~s;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= s_tuser;
            off_reg <= s_tdata[OFF_W-1:0];
            wd_reg  <= s_tdata[OFF_W +: DATA_W];
        end
    end

    assign in_win = {1'b0, off_reg} < 8'(REG_WINDOW);
    assign rf_idx = off_reg[RF_AW-1:0];

    always_comb
    begin
        is_flop = 1'b0;
        if (off_reg >= OFF_GPIO_FIRST && off_reg <= OFF_GPIO_LAST)
        begin
            is_flop = 1'b1;
        end
        case (off_reg)
            OFF_IRQ_STATUS, OFF_ADC_CTRL, OFF_UART_STATUS, OFF_I2C_CMD,
            OFF_I2C_STATUS, OFF_I2C_DEV, OFF_I2C_SUB, OFF_I2C_DOUT, OFF_I2C_DIN:
            begin
                is_flop = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign is_write = cmd.execute && (op_reg == OP_WRITE) && in_win;
    // UART transmit writes are dropped
    assign rf_wr    = is_write && !is_flop && (off_reg != OFF_UART_TX);
    assign i2c_go   = is_write && (off_reg == OFF_I2C_CMD);
    assign eep_wr   = i2c_go && ((wd_reg & I2C_CMD_READ) == '0);

    // EEPROM address folded into the store depth; raw value stays below 1024, and the fold is exact below 4x depth
    assign eep_raw  = ((12'(i2c_dev_reg & I2C_DEV_MASK)) << 7) | {4'h0, i2c_sub_reg[7:0]};
    assign eep_m1   = (eep_raw >= EEP_D2) ? (eep_raw - EEP_D2) : eep_raw;
    assign eep_m2   = (eep_m1 >= EEP_D1) ? (eep_m1 - EEP_D1) : eep_m1;
    assign eep_addr = eep_m2[EEP_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < GPIO_PORTS; p++)
            begin
                gpio_buf_reg[p]  <= '0;
                gpio_dir_reg[p]  <= '0;
                gpio_attr_reg[p] <= '0;
                gpio_spec_reg[p] <= '0;
            end
            irq_reg      <= '0;
            adc_reg      <= '0;
            i2c_cmd_reg  <= '0;
            i2c_stat_reg <= '0;
            i2c_dev_reg  <= '0;
            i2c_sub_reg  <= '0;
            i2c_dout_reg <= '0;
            i2c_din_reg  <= '0;
            eep_rd_reg   <= 1'b0;
            rf_valid_reg <= '0;
        end
        else
        begin
            if (cmd.execute)
            begin
                case (op_reg)
                    OP_READ:
                    begin
                    end
                    OP_WRITE:
                    begin
                        if (in_win)
                        begin
                            // the data offset and the buffer offset of a port both write its buffer
                            for (int p = 0; p < GPIO_PORTS; p++)
                            begin
                                if (off_reg == 7'(1 + 5 * p) || off_reg == 7'(2 + 5 * p))
                                begin
                                    gpio_buf_reg[p] <= wd_reg;
                                end
                                if (off_reg == 7'(3 + 5 * p))
                                begin
                                    gpio_dir_reg[p] <= wd_reg;
                                end
                                if (off_reg == 7'(4 + 5 * p))
                                begin
                                    gpio_attr_reg[p] <= wd_reg;
                                end
                                if (off_reg == 7'(5 + 5 * p))
                                begin
                                    gpio_spec_reg[p] <= wd_reg;
                                end
                            end
                            case (off_reg)
                                OFF_IRQ_STATUS: irq_reg <= irq_reg & ~wd_reg;
                                OFF_ADC_CTRL:
                                    adc_reg <= ((wd_reg | adc_reg) & ADC_W1C_MASK) ^ wd_reg;
                                OFF_I2C_CMD:
                                begin
                                    i2c_cmd_reg  <= wd_reg;
                                    i2c_stat_reg <= i2c_stat_reg | I2C_DONE;
                                end
                                OFF_I2C_STATUS: i2c_stat_reg <= i2c_stat_reg & ~wd_reg;
                                OFF_I2C_DEV:    i2c_dev_reg  <= wd_reg;
                                OFF_I2C_SUB:    i2c_sub_reg  <= wd_reg;
                                OFF_I2C_DOUT:   i2c_dout_reg <= wd_reg;
                                OFF_I2C_DIN:    i2c_din_reg  <= wd_reg;
                                default:
                                begin
                                end
                            endcase
                            if (rf_wr)
                            begin
                                rf_valid_reg[rf_idx] <= 1'b1;
                            end
                        end
                    end
                    OP_TICK1: irq_reg <= irq_reg | IRQ_TICK1;
                    OP_TICK2: irq_reg <= irq_reg | IRQ_TICK2;
                    default:
                    begin
                    end
                endcase
                eep_rd_reg <= i2c_go && !eep_wr;
            end
            if (cmd.finish)
            begin
                // EEPROM byte fetched during execute lands in the data-in register
                if (eep_rd_reg)
                begin
                    i2c_din_reg <= {8'h00, eep_q_reg};
                end
                eep_rd_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_wr)
        begin
            rf_mem[rf_idx] <= wd_reg;
        end
        rf_q_reg   <= rf_mem[rf_idx];
        rf_hit_reg <= rf_valid_reg[rf_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            eep_mem[clr_cnt_reg] <= '0;
        end
        else if (eep_wr)
        begin
            eep_mem[eep_addr] <= i2c_dout_reg[7:0];
        end
        eep_q_reg <= eep_mem[eep_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        flop_rd = '0;
        for (int p = 0; p < GPIO_PORTS; p++)
        begin
            if (off_reg == 7'(1 + 5 * p))
            begin
                flop_rd = gpio_data(gpio_buf_reg[p], gpio_dir_reg[p],
                                    gpio_attr_reg[p], gpio_spec_reg[p]);
            end
            if (off_reg == 7'(2 + 5 * p))
            begin
                flop_rd = gpio_buf_reg[p];
            end
            if (off_reg == 7'(3 + 5 * p))
            begin
                flop_rd = gpio_dir_reg[p];
            end
            if (off_reg == 7'(4 + 5 * p))
            begin
                flop_rd = gpio_attr_reg[p];
            end
            if (off_reg == 7'(5 + 5 * p))
            begin
                flop_rd = gpio_spec_reg[p];
            end
        end
        case (off_reg)
            OFF_IRQ_STATUS:  flop_rd = irq_reg;
            OFF_ADC_CTRL:    flop_rd = adc_reg;
            OFF_UART_STATUS: flop_rd = UART_STAT_READ;
            OFF_I2C_CMD:     flop_rd = i2c_cmd_reg;
            OFF_I2C_STATUS:  flop_rd = i2c_stat_reg;
            OFF_I2C_DEV:     flop_rd = i2c_dev_reg;
            OFF_I2C_SUB:     flop_rd = i2c_sub_reg;
            OFF_I2C_DOUT:    flop_rd = i2c_dout_reg;
            OFF_I2C_DIN:     flop_rd = i2c_din_reg;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result = '0;
        if (op_reg == OP_READ && in_win)
        begin
            if (is_flop)
            begin
                result = flop_rd;
            end
            else if (rf_hit_reg)
            begin
                result = rf_q_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid          = m_tvalid_reg;
    assign m_tdata           = m_tdata_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;
    assign status.clear_last = (clr_cnt_reg == EEP_AW'(EEPROM_DEPTH - 1));

endmodule

`default_nettype wire

### src/soc_io_register_block.sv
// I/O register block: an accepted transaction passes the capture, execute and finish
// steps, with registered reads of the register file and EEPROM memories between execute
// and finish; a stalled output holds the finish step. One transaction is in flight at a time.
// Reset zeroes the special registers and register-file valid bits at once, then sweeps
// all EEPROM_DEPTH bytes (1024 by default) of the EEPROM store, one byte a cycle, with s_tready low.
`default_nettype none
`include "soc_io_register_block_assert.svh"

module soc_io_register_block #(
    parameter int EEPROM_DEPTH = sirb_pkg::EEPROM_DEPTH_DEF,
    parameter int REG_WINDOW   = sirb_pkg::REG_WINDOW_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sirb_pkg::S_TDATA_W-1:0] s_tdata,   // reg_offset[6:0], write_data[22:7]
    input  logic [sirb_pkg::OP_W-1:0]      s_tuser,   // op[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sirb_pkg::DATA_W-1:0]    m_tdata    // read_data[15:0]
);
    import sirb_pkg::*;

    cmd_t    cmd;
    status_t stat;

    sirb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (stat)
    );

    sirb_datapath #(
        .EEPROM_DEPTH (EEPROM_DEPTH),
        .REG_WINDOW   (REG_WINDOW)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (stat)
    );

    `SIRB_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "new transaction accepted while one is in flight")
    `SIRB_ASSERT_SAME(a_no_accept_in_sweep, clk, rst_n, cmd.clear_step, !s_tready,
        "input ready during EEPROM clear sweep")
    `SIRB_ASSERT_SAME(a_finish_has_slot, clk, rst_n, cmd.finish, stat.out_free,
        "result formed while output register still held")

endmodule

`default_nettype wire
